/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the Q24.8 fixed-point ALU
// Opcodes, payload structs and the division cell record.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 8;
  // dividend magnitude shifted left by FRAC_BITS, one quotient bit per cell
  localparam int NUM_WIDTH  = WORD_WIDTH + FRAC_BITS;
  localparam int NUM_CELLS  = NUM_WIDTH;
  localparam int MAG_WIDTH  = WORD_WIDTH + 1;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_GE  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_MIN = 4'd10;
  localparam logic [3:0] OP_MAX = 4'd11;
  localparam logic [3:0] OP_INC = 4'd12;
  localparam logic [3:0] OP_DEC = 4'd13;
  localparam logic [3:0] OP_I2F = 4'd14;
  localparam logic [3:0] OP_F2I = 4'd15;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [WORD_WIDTH-1:0] a_raw;
    logic signed [WORD_WIDTH-1:0] b_raw;
  } fpa_in_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] result_raw;
    logic                     cond;
    logic                     overflow;
    logic                     div_zero;
  } fpa_out_t;

  // record carried down the chain, one per item in flight
  typedef struct packed {
    logic                     valid;
    logic                     is_div;
    logic                     neg;     // result sign for mul/div
    logic                     dz;      // divide by zero
    logic                     a_neg;
    logic [MAG_WIDTH-1:0]     den;     // divisor magnitude
    logic [MAG_WIDTH:0]       rem;     // partial remainder
    logic [NUM_WIDTH-1:0]     num;     // dividend bits shifting out, quotient in
    logic [WORD_WIDTH-1:0]    early;   // finished result of non-divide ops
    logic                     cond;
    logic                     ovf;
  } fpa_cell_t;

  // apply sign to a magnitude with saturation; returns {ovf, word}
  function automatic logic [WORD_WIDTH:0] sat_sign(input logic neg,
                                                   input logic [NUM_WIDTH:0] m);
    logic [WORD_WIDTH:0] r;
    logic [NUM_WIDTH:0]  lim;
    lim = {{(NUM_WIDTH-WORD_WIDTH+1){1'b0}}, 1'b1, {(WORD_WIDTH-1){1'b0}}};
    if (!neg && m >= lim) begin
      r = {1'b1, 1'b0, {(WORD_WIDTH-1){1'b1}}};
    end else if (neg && m > lim) begin
      r = {1'b1, 1'b1, {(WORD_WIDTH-1){1'b0}}};
    end else if (neg) begin
      r = {1'b0, WORD_WIDTH'(~m + 1'b1)};
    end else begin
      r = {1'b0, m[WORD_WIDTH-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/fpa_cell.sv */
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// Brings down one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell
  import fpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fpa_cell_t din,
  output fpa_cell_t      dout
);

  fpa_cell_t nxt;
  logic [MAG_WIDTH+1:0] trial;
  logic [MAG_WIDTH:0]   shifted;

  always_comb begin
    nxt = din;
    shifted = {din.rem[MAG_WIDTH-1:0], din.num[NUM_WIDTH-1]};
    trial = {1'b0, shifted} - {2'b00, din.den};
    nxt.num = {din.num[NUM_WIDTH-2:0], 1'b0};
    if (!trial[MAG_WIDTH+1]) begin
      nxt.rem = trial[MAG_WIDTH:0];
      nxt.num[0] = 1'b1;
    end else begin
      nxt.rem = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.is_div <= nxt.is_div;
    dout.neg    <= nxt.neg;
    dout.dz     <= nxt.dz;
    dout.a_neg  <= nxt.a_neg;
    dout.den    <= nxt.den;
    dout.rem    <= nxt.rem;
    dout.num    <= nxt.num;
    dout.early  <= nxt.early;
    dout.cond   <= nxt.cond;
    dout.ovf    <= nxt.ovf;
  end

endmodule

`default_nettype wire

/* hdl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front: operand decode and every op but the division steps
// Registers the transfer; computes add/sub/compare/convert and the
// registered product of magnitudes, rounded and saturated one stage on.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front
  import fpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire fpa_in_t   din,
  output fpa_cell_t      dout
);

  logic [3:0]            op_q;
  logic                  v_q;
  logic [WORD_WIDTH-1:0] a_q, b_q;
  logic [2*WORD_WIDTH-1:0] prod_q;
  logic [WORD_WIDTH-1:0] ma, mb;

  assign ma = din.a_raw[WORD_WIDTH-1] ? WORD_WIDTH'(-din.a_raw) : din.a_raw;
  assign mb = din.b_raw[WORD_WIDTH-1] ? WORD_WIDTH'(-din.b_raw) : din.b_raw;

  // stage 1: register operands and the magnitude product
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= start;
    end
    op_q   <= din.op;
    a_q    <= din.a_raw;
    b_q    <= din.b_raw;
    prod_q <= ma * mb;
  end

  // stage 2: everything except the division steps
  logic                  lt, gt, eq, neg;
  logic [WORD_WIDTH:0]   mag_a, mag_b;
  logic [NUM_WIDTH:0]    pround;
  logic [WORD_WIDTH:0]   psat;
  logic [2*WORD_WIDTH:0] psum;
  fpa_cell_t             nxt;

  always_comb begin
    lt = $signed(a_q) < $signed(b_q);
    gt = $signed(a_q) > $signed(b_q);
    eq = a_q == b_q;
    neg = a_q[WORD_WIDTH-1] ^ b_q[WORD_WIDTH-1];
    mag_a = a_q[WORD_WIDTH-1] ? (MAG_WIDTH)'(-{1'b1, a_q}) : {1'b0, a_q};
    mag_b = b_q[WORD_WIDTH-1] ? (MAG_WIDTH)'(-{1'b1, b_q}) : {1'b0, b_q};
    psum = {1'b0, prod_q} + (2*WORD_WIDTH+1)'(1 << (FRAC_BITS-1));
    // clamp the shifted product into NUM_WIDTH+1 bits before saturation
    if (|psum[2*WORD_WIDTH:NUM_WIDTH+FRAC_BITS]) begin
      pround = {1'b1, {NUM_WIDTH{1'b0}}};
    end else begin
      pround = psum[NUM_WIDTH+FRAC_BITS:FRAC_BITS];
    end
    psat = sat_sign(neg, pround);

    nxt = '0;
    nxt.valid = v_q;
    nxt.neg   = neg;
    nxt.a_neg = a_q[WORD_WIDTH-1];
    nxt.den   = mag_b;
    nxt.num   = {mag_a[WORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
    case (op_q)
      OP_ADD: nxt.early = a_q + b_q;
      OP_SUB: nxt.early = a_q - b_q;
      OP_MUL: begin
        nxt.early = psat[WORD_WIDTH-1:0];
        nxt.ovf   = psat[WORD_WIDTH];
      end
      OP_DIV: begin
        nxt.is_div = 1'b1;
        nxt.dz     = (b_q == '0);
      end
      OP_GT:  nxt.cond = gt;
      OP_LT:  nxt.cond = lt;
      OP_GE:  nxt.cond = !lt;
      OP_LE:  nxt.cond = !gt;
      OP_EQ:  nxt.cond = eq;
      OP_NE:  nxt.cond = !eq;
      OP_MIN: nxt.early = lt ? a_q : b_q;
      OP_MAX: nxt.early = gt ? a_q : b_q;
      OP_INC: nxt.early = a_q + 1'b1;
      OP_DEC: nxt.early = a_q - 1'b1;
      OP_I2F: nxt.early = {a_q[WORD_WIDTH-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      OP_F2I: nxt.early = WORD_WIDTH'($signed(a_q) >>> FRAC_BITS);
      default: nxt.early = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= nxt.valid;
    end
    dout.is_div <= nxt.is_div;
    dout.neg    <= nxt.neg;
    dout.dz     <= nxt.dz;
    dout.a_neg  <= nxt.a_neg;
    dout.den    <= nxt.den;
    dout.rem    <= nxt.rem;
    dout.num    <= nxt.num;
    dout.early  <= nxt.early;
    dout.cond   <= nxt.cond;
    dout.ovf    <= nxt.ovf;
  end

endmodule

`default_nettype wire

/* hdl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu: signed Q24.8 fixed-point ALU
// Add, subtract, exact rounded multiply and divide, compares, min/max,
// increment/decrement and integer/fixed conversions.
// ----------------------------------------------------------------------------
// A new transfer is taken every cycle (busy is always low) and every
// result appears on strobe for one cycle, in order; the receiver cannot
// stall it. The pipeline is a chain of 40 identical restoring-division
// cells, one quotient bit per cell, behind two front stages (operand
// register with the 32x32 magnitude product, then decode of the other
// ops) and a final rounding/saturation stage. Every op rides the same
// chain so all results keep the same latency. Multiply and divide round
// half away from zero and saturate with overflow; divide by zero
// saturates by the dividend sign and raises div_zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu
  import fpa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire fpa_in_t in_item,
  output logic         strobe,
  output fpa_out_t     out_item
);

  assign busy = 1'b0;

  fpa_cell_t chain [NUM_CELLS+1];

  fpa_front u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .din  (in_item),
    .dout (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // final stage: round the quotient using the remainder, saturate
  fpa_cell_t          t;
  logic [MAG_WIDTH:0] twice_rem;
  logic [NUM_WIDTH:0] q_round;
  logic [WORD_WIDTH:0] qsat;
  fpa_out_t           res;

  always_comb begin
    t = chain[NUM_CELLS];
    // rem >= den - rem  <=>  2*rem >= den
    twice_rem = {t.rem[MAG_WIDTH-1:0], 1'b0};
    q_round = {1'b0, t.num} + (NUM_WIDTH+1)'(twice_rem >= {1'b0, t.den});
    qsat = sat_sign(t.neg, q_round);
    res = '0;
    if (t.is_div) begin
      if (t.dz) begin
        res.div_zero = 1'b1;
        res.result_raw = t.a_neg ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                                 : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else begin
        res.result_raw = qsat[WORD_WIDTH-1:0];
        res.overflow   = qsat[WORD_WIDTH];
      end
    end else begin
      res.result_raw = t.early;
      res.cond       = t.cond;
      res.overflow   = t.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= t.valid;
    end
    out_item <= res;
  end

endmodule

`default_nettype wire
